[hdl/sep_pkg.sv]
// Shared types, constants and tables for the superellipse point generator.
// Depends on nothing; every other file imports it.
package sep_pkg;

  // Scalable formats
  localparam int ANGLE_BITS      = 16;
  localparam int COORD_FRAC_BITS = 4;

  // Fixed field widths
  localparam int PHASE_W = 16;
  localparam int T_W     = 14;
  localparam int Q_W     = 31;
  localparam int CX_W    = 11;
  localparam int AX_W    = 10;
  localparam int EXP_W   = 15;
  localparam int PT_W    = 17;
  localparam int IDX_W   = 3;
  localparam int RCP_W   = 32;
  localparam int DVS_W   = 7;
  localparam int SH_W    = 5;
  localparam int FRAC_W  = 16;

  localparam logic [Q_W-1:0] Q30_ONE     = 31'h4000_0000;
  localparam logic [Q_W-1:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [29:0]    LN2_Q30     = 30'd744261118;
  localparam logic [63:0]    RCP_NUM     = 64'h8000_0000;

  // Pipeline depths
  localparam int HORNER_LAT = 3;
  localparam int TRIG_STEPS = 4;
  localparam int EXP_TERMS  = 12;
  localparam int LOG_STEPS  = 16;
  localparam int DIV_BITS   = 30;
  localparam int TRIG_LAT   = 2 + TRIG_STEPS * HORNER_LAT + 1;
  localparam int LANE_LAT   = 2 + LOG_STEPS + 1 + DIV_BITS + 1 + EXP_TERMS * HORNER_LAT + 3;

  // Angle alignment to 16 bits
  localparam int ANG_SH_R = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
  localparam int ANG_SH_L = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;

  // Output arithmetic
  localparam int TERM_W = 11 + COORD_FRAC_BITS;
  localparam int V_W    = (COORD_FRAC_BITS + 13 > 18) ? COORD_FRAC_BITS + 13 : 18;

  // Series divisors and their reciprocals floor(2^31 / d)
  localparam logic [DVS_W-1:0] COS_DIV [TRIG_STEPS] = '{7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [RCP_W-1:0] COS_RCP [TRIG_STEPS] = '{
    32'(RCP_NUM / 56), 32'(RCP_NUM / 30), 32'(RCP_NUM / 12), 32'(RCP_NUM / 2)};
  localparam logic [DVS_W-1:0] SIN_DIV [TRIG_STEPS] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [RCP_W-1:0] SIN_RCP [TRIG_STEPS] = '{
    32'(RCP_NUM / 72), 32'(RCP_NUM / 42), 32'(RCP_NUM / 20), 32'(RCP_NUM / 6)};
  localparam logic [DVS_W-1:0] EXP_DIV [EXP_TERMS] = '{
    7'd12, 7'd11, 7'd10, 7'd9, 7'd8, 7'd7, 7'd6, 7'd5, 7'd4, 7'd3, 7'd2, 7'd1};
  localparam logic [RCP_W-1:0] EXP_RCP [EXP_TERMS] = '{
    32'(RCP_NUM / 12), 32'(RCP_NUM / 11), 32'(RCP_NUM / 10), 32'(RCP_NUM / 9),
    32'(RCP_NUM / 8), 32'(RCP_NUM / 7), 32'(RCP_NUM / 6), 32'(RCP_NUM / 5),
    32'(RCP_NUM / 4), 32'(RCP_NUM / 3), 32'(RCP_NUM / 2), 32'(RCP_NUM / 1)};

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_AXIS_X    = 3'd2,
    REG_AXIS_Y    = 3'd3,
    REG_SHAPE_EXP = 3'd4
  } sep_reg_t;

  typedef struct packed {
    logic x_from_sin;
    logic x_neg;
    logic y_neg;
  } sep_tag_t;

  typedef struct packed {
    sep_tag_t       tag;
    logic [T_W-1:0] t;
  } sep_item_t;

  function automatic logic [15:0] angle16(input logic [PHASE_W-1:0] phase);
    return 16'((phase >> ANG_SH_R) << ANG_SH_L);
  endfunction

endpackage

[hdl/sep_front.sv]
// Request front end: accepts a phase, folds it to one octant and tags quadrant signs.
// Depends on sep_pkg.
module sep_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [15:0]                phase_turns,
  output logic                       busy,
  input  logic                       q_ready,
  output logic                       item_valid,
  output sep_pkg::sep_item_t         item
);
  import sep_pkg::*;

  logic [15:0]    a16;
  logic [1:0]     quad;
  logic [T_W-1:0] t_raw;
  logic           swap;
  sep_item_t      item_next;
  logic           accept;

  always_comb begin
    a16   = angle16(phase_turns);
    quad  = a16[15:14];
    t_raw = a16[T_W-1:0];
    swap  = t_raw > 14'd8192;
    item_next.t              = swap ? 14'(15'd16384 - {1'b0, t_raw}) : t_raw;
    item_next.tag.x_from_sin = swap ^ quad[0];
    item_next.tag.x_neg      = quad[1] ^ quad[0];
    item_next.tag.y_neg      = quad[1];
  end

  assign busy   = item_valid & ~q_ready;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (q_ready) begin
      item_valid <= 1'b0;
    end
  end

  // hold the payload until the queue takes it
  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

[hdl/sep_queue.sv]
// Two-entry request queue between the front end and the arithmetic back end.
// Depends on sep_pkg.
module sep_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  sep_pkg::sep_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output sep_pkg::sep_item_t  out_item
);
  import sep_pkg::*;

  sep_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign out_item  = mem[rd_ptr];
  assign push      = in_valid & in_ready;
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

[hdl/sep_horner.sv]
// One Horner step h' = 1 - ((x * h) >> 30) / d in Q30, three register stages.
// The constant divide is a reciprocal multiply plus one correction. Depends on sep_pkg.
module sep_horner (
  input  logic                       clk,
  input  logic [sep_pkg::Q_W-1:0]    x_in,
  input  logic [sep_pkg::Q_W-1:0]    h_in,
  input  logic [sep_pkg::DVS_W-1:0]  divisor,
  input  logic [sep_pkg::RCP_W-1:0]  recip,
  output logic [sep_pkg::Q_W-1:0]    x_out,
  output logic [sep_pkg::Q_W-1:0]    h_out
);
  import sep_pkg::*;

  logic [61:0]    prod_full;
  logic [62:0]    quot_full;
  logic [37:0]    qd;
  logic [Q_W-1:0] rem;
  logic [Q_W-1:0] quot;
  logic [Q_W-1:0] x1, x2;
  logic [Q_W-1:0] prod1, prod2;
  logic [Q_W-1:0] q0;

  assign prod_full = 62'(x_in) * 62'(h_in);
  assign quot_full = 63'(prod1) * 63'(recip);
  assign qd        = 38'(q0) * 38'(divisor);
  assign rem       = prod2 - qd[Q_W-1:0];
  assign quot      = q0 + Q_W'(rem >= Q_W'(divisor));

  always_ff @(posedge clk) begin
    x1    <= x_in;
    prod1 <= prod_full[60:30];
    x2    <= x1;
    prod2 <= prod1;
    q0    <= quot_full[61:31];
    x_out <= x2;
    h_out <= Q30_ONE - quot;
  end

endmodule

[hdl/sep_trig.sv]
// Octant cosine and sine in Q30 from truncated series, fully pipelined.
// Depends on sep_pkg and sep_horner.
module sep_trig (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  sep_pkg::sep_tag_t        in_tag,
  input  logic [sep_pkg::T_W-1:0]  in_t,
  output logic                     out_valid,
  output sep_pkg::sep_tag_t        out_tag,
  output logic [sep_pkg::Q_W-1:0]  out_cos,
  output logic [sep_pkg::Q_W-1:0]  out_sin
);
  import sep_pkg::*;

  localparam int TH_DLY = TRIG_STEPS * HORNER_LAT;

  logic [44:0]    th_full;
  logic [61:0]    sq_full;
  logic [61:0]    sin_full;
  logic [Q_W-1:0] th1, th2, x2q;
  logic [Q_W-1:0] th_d [TH_DLY];
  logic           tv   [TRIG_LAT];
  sep_tag_t       tg   [TRIG_LAT];
  logic [Q_W-1:0] cx [TRIG_STEPS];
  logic [Q_W-1:0] ch [TRIG_STEPS+1];
  logic [Q_W-1:0] sx [TRIG_STEPS];
  logic [Q_W-1:0] sh [TRIG_STEPS+1];

  assign th_full  = 45'(in_t) * 45'(HALF_PI_Q30);
  assign sq_full  = 62'(th1) * 62'(th1);
  assign sin_full = 62'(th_d[TH_DLY-1]) * 62'(sh[TRIG_STEPS]);

  assign cx[0] = x2q;
  assign ch[0] = Q30_ONE;
  assign sx[0] = x2q;
  assign sh[0] = Q30_ONE;

  for (genvar k = 0; k < TRIG_STEPS; k++) begin : g_step
    if (k < TRIG_STEPS - 1) begin : g_mid
      sep_horner u_cos (
        .clk(clk), .x_in(cx[k]), .h_in(ch[k]), .divisor(COS_DIV[k]), .recip(COS_RCP[k]),
        .x_out(cx[k+1]), .h_out(ch[k+1]));
      sep_horner u_sin (
        .clk(clk), .x_in(sx[k]), .h_in(sh[k]), .divisor(SIN_DIV[k]), .recip(SIN_RCP[k]),
        .x_out(sx[k+1]), .h_out(sh[k+1]));
    end else begin : g_last
      sep_horner u_cos (
        .clk(clk), .x_in(cx[k]), .h_in(ch[k]), .divisor(COS_DIV[k]), .recip(COS_RCP[k]),
        .x_out(), .h_out(ch[k+1]));
      sep_horner u_sin (
        .clk(clk), .x_in(sx[k]), .h_in(sh[k]), .divisor(SIN_DIV[k]), .recip(SIN_RCP[k]),
        .x_out(), .h_out(sh[k+1]));
    end
  end

  always_ff @(posedge clk) begin
    th1 <= th_full[44:14];
    th2 <= th1;
    x2q <= sq_full[60:30];
    th_d[0] <= th2;
    for (int j = 1; j < TH_DLY; j++) begin
      th_d[j] <= th_d[j-1];
    end
    out_cos <= ch[TRIG_STEPS];
    out_sin <= sin_full[60:30];
    tg[0] <= in_tag;
    for (int j = 1; j < TRIG_LAT; j++) begin
      tg[j] <= tg[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < TRIG_LAT; j++) begin
        tv[j] <= 1'b0;
      end
    end else begin
      tv[0] <= in_valid;
      for (int j = 1; j < TRIG_LAT; j++) begin
        tv[j] <= tv[j-1];
      end
    end
  end

  assign out_valid = tv[TRIG_LAT-1];
  assign out_tag   = tg[TRIG_LAT-1];

endmodule

[hdl/sep_lane.sv]
// One coordinate lane: |v|^(2/n) via log2, divide and exp2, then scale, offset, saturate.
// Depends on sep_pkg and sep_horner.
module sep_lane (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [sep_pkg::Q_W-1:0]     in_mag,
  input  logic                        in_neg,
  input  logic [sep_pkg::CX_W-1:0]    center,
  input  logic [sep_pkg::AX_W-1:0]    axis,
  input  logic [sep_pkg::EXP_W-1:0]   shape,
  output logic                        out_valid,
  output logic signed [sep_pkg::PT_W-1:0] out_point
);
  import sep_pkg::*;

  localparam int EXP_LAT = EXP_TERMS * HORNER_LAT;
  localparam logic [40:0] RND = 41'(1) << (29 - COORD_FRAC_BITS);
  localparam logic signed [V_W-1:0] VMAX = V_W'(65535);
  localparam logic signed [V_W-1:0] VMIN = V_W'(-65536);

  // side info per stage
  logic sv [LANE_LAT];
  logic sz [LANE_LAT];
  logic sn [LANE_LAT];

  // normalize
  logic [SH_W-1:0] msb;
  logic [Q_W-1:0]  m1;
  logic [SH_W-1:0] msb1;

  // log2 by repeated squaring
  logic [Q_W-1:0]    sq_x [LOG_STEPS+1];
  logic [FRAC_W-1:0] sq_f [LOG_STEPS+1];
  logic [SH_W-1:0]   sq_k [LOG_STEPS+1];
  logic [61:0]       sq_p [LOG_STEPS];
  logic [20:0]       lg;

  // restoring divide of L * 512 by the exponent
  logic [EXP_W-1:0]    e_eff;
  logic [EXP_W-1:0]    dv_r  [DIV_BITS+1];
  logic [DIV_BITS-1:0] dv_nq [DIV_BITS+1];
  logic [EXP_W:0]      dv_t  [DIV_BITS];
  logic                dv_ge [DIV_BITS];

  // exp2 of the fraction
  logic [45:0]     y_full;
  logic [13:0]     ip;
  logic [Q_W-1:0]  ex [EXP_TERMS];
  logic [Q_W-1:0]  eh [EXP_TERMS+1];
  logic            bs_big [EXP_LAT];
  logic [SH_W-1:0] bs_sh  [EXP_LAT];
  logic [Q_W-1:0]  y50;
  logic            big50;
  logic [SH_W-1:0] sh50;

  // output arithmetic
  logic [Q_W-1:0]          pw;
  logic [40:0]             tprod;
  logic [TERM_W-1:0]       term;
  logic signed [V_W-1:0]   cen_s;
  logic signed [V_W-1:0]   v;

  always_comb begin
    msb = '0;
    for (int i = 1; i < Q_W; i++) begin
      if (in_mag[i]) begin
        msb = SH_W'(i);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < LOG_STEPS; j++) begin
      sq_p[j] = 62'(sq_x[j]) * 62'(sq_x[j]);
    end
  end

  assign lg    = {sq_k[LOG_STEPS], 16'b0} - {5'b0, sq_f[LOG_STEPS]};
  assign e_eff = (shape == '0) ? EXP_W'(1) : shape;

  always_comb begin
    for (int j = 0; j < DIV_BITS; j++) begin
      dv_t[j]  = {dv_r[j], dv_nq[j][DIV_BITS-1]};
      dv_ge[j] = dv_t[j] >= {1'b0, e_eff};
    end
  end

  assign ip     = dv_nq[DIV_BITS][29:16];
  assign y_full = 46'(dv_nq[DIV_BITS][15:0]) * 46'(LN2_Q30);

  assign ex[0] = y50;
  assign eh[0] = Q30_ONE;

  for (genvar k = 0; k < EXP_TERMS; k++) begin : g_exp
    if (k < EXP_TERMS - 1) begin : g_mid
      sep_horner u_term (
        .clk(clk), .x_in(ex[k]), .h_in(eh[k]), .divisor(EXP_DIV[k]), .recip(EXP_RCP[k]),
        .x_out(ex[k+1]), .h_out(eh[k+1]));
    end else begin : g_last
      sep_horner u_term (
        .clk(clk), .x_in(ex[k]), .h_in(eh[k]), .divisor(EXP_DIV[k]), .recip(EXP_RCP[k]),
        .x_out(), .h_out(eh[k+1]));
    end
  end

  assign tprod = 41'(pw) * 41'(axis) + RND;
  assign cen_s = signed'(V_W'(center)) <<< COORD_FRAC_BITS;
  assign v     = sn[LANE_LAT-2] ? cen_s - signed'(V_W'(term)) : cen_s + signed'(V_W'(term));

  always_ff @(posedge clk) begin
    m1   <= in_mag;
    msb1 <= msb;
    sq_k[0] <= SH_W'(30) - msb1;
    sq_x[0] <= m1 << (SH_W'(30) - msb1);
    sq_f[0] <= '0;
    for (int j = 0; j < LOG_STEPS; j++) begin
      sq_k[j+1] <= sq_k[j];
      if (sq_p[j][61]) begin
        sq_x[j+1] <= sq_p[j][61:31];
        sq_f[j+1] <= {sq_f[j][FRAC_W-2:0], 1'b1};
      end else begin
        sq_x[j+1] <= sq_p[j][60:30];
        sq_f[j+1] <= {sq_f[j][FRAC_W-2:0], 1'b0};
      end
    end
    dv_r[0]  <= '0;
    dv_nq[0] <= {lg, 9'b0};
    for (int j = 0; j < DIV_BITS; j++) begin
      dv_r[j+1]  <= dv_ge[j] ? EXP_W'(dv_t[j] - {1'b0, e_eff}) : dv_t[j][EXP_W-1:0];
      dv_nq[j+1] <= {dv_nq[j][DIV_BITS-2:0], dv_ge[j]};
    end
    y50   <= {1'b0, y_full[45:16]};
    big50 <= ip >= 14'd31;
    sh50  <= ip[SH_W-1:0];
    bs_big[0] <= big50;
    bs_sh[0]  <= sh50;
    for (int j = 1; j < EXP_LAT; j++) begin
      bs_big[j] <= bs_big[j-1];
      bs_sh[j]  <= bs_sh[j-1];
    end
    // drop vanishing powers and zero trig values
    if (bs_big[EXP_LAT-1] || sz[LANE_LAT-4]) begin
      pw <= '0;
    end else begin
      pw <= eh[EXP_TERMS] >> bs_sh[EXP_LAT-1];
    end
    term <= tprod[40:30-COORD_FRAC_BITS];
    if (v > VMAX) begin
      out_point <= PT_W'(VMAX);
    end else if (v < VMIN) begin
      out_point <= PT_W'(VMIN);
    end else begin
      out_point <= PT_W'(v);
    end
    sz[0] <= in_mag == '0;
    sn[0] <= in_neg;
    for (int j = 1; j < LANE_LAT; j++) begin
      sz[j] <= sz[j-1];
      sn[j] <= sn[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < LANE_LAT; j++) begin
        sv[j] <= 1'b0;
      end
    end else begin
      sv[0] <= in_valid;
      for (int j = 1; j < LANE_LAT; j++) begin
        sv[j] <= sv[j-1];
      end
    end
  end

  assign out_valid = sv[LANE_LAT-1];

endmodule

[hdl/superellipse_point_generator.sv]
// Top level of the superellipse point generator: register file, front end, queue,
// trig pipeline and two coordinate lanes. Depends on sep_pkg and all sep_* modules.
//
//  channel   | signals                                   | flow control
//  ----------+-------------------------------------------+---------------------------
//  request   | start, busy, phase_turns                  | taken when start & !busy
//  config    | cfg_valid, cfg_ready, cfg_index, cfg_data | written when valid & ready
//  result    | done, point_x, point_y                    | one-cycle strobe, no stall
//
// One request per clock is accepted and one point per clock comes out. The accepting
// edge loads the front register; the request then passes the queue register, the trig
// pipeline and each lane (16 squaring stages, a 30-stage divider and a 12-term series)
// before the done strobe. Reset clears every valid bit and loads the register
// defaults; no clearing pass is needed. The result side never stalls, so busy only
// rises if the queue fills, which the pipeline never lets happen.
module superellipse_point_generator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [sep_pkg::PHASE_W-1:0]       phase_turns,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sep_pkg::IDX_W-1:0]         cfg_index,
  input  logic [sep_pkg::EXP_W-1:0]         cfg_data,
  output logic                              done,
  output logic signed [sep_pkg::PT_W-1:0]   point_x,
  output logic signed [sep_pkg::PT_W-1:0]   point_y
);
  import sep_pkg::*;

  logic [CX_W-1:0]  center_x;
  logic [CX_W-1:0]  center_y;
  logic [AX_W-1:0]  axis_x_len;
  logic [AX_W-1:0]  axis_y_len;
  logic [EXP_W-1:0] shape_exponent;

  logic       f_valid;
  sep_item_t  f_item;
  logic       q_in_ready;
  logic       q_valid;
  sep_item_t  q_item;

  logic           t_valid;
  sep_tag_t       t_tag;
  logic [Q_W-1:0] t_cos;
  logic [Q_W-1:0] t_sin;
  logic [Q_W-1:0] mag_x;
  logic [Q_W-1:0] mag_y;
  logic           x_valid;
  logic           y_valid;

  // Registers are always ready; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= 11'd512;
      center_y       <= 11'd384;
      axis_x_len     <= 10'd100;
      axis_y_len     <= 10'd100;
      shape_exponent <= 15'd2560;
    end else if (cfg_valid && cfg_ready) begin
      case (sep_reg_t'(cfg_index))
        REG_CENTER_X:  center_x       <= cfg_data[CX_W-1:0];
        REG_CENTER_Y:  center_y       <= cfg_data[CX_W-1:0];
        REG_AXIS_X:    axis_x_len     <= cfg_data[AX_W-1:0];
        REG_AXIS_Y:    axis_y_len     <= cfg_data[AX_W-1:0];
        REG_SHAPE_EXP: shape_exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  // Front end: fold the angle and register the request.
  sep_front u_front (
    .clk(clk), .rst(rst), .start(start), .phase_turns(phase_turns), .busy(busy),
    .q_ready(q_in_ready), .item_valid(f_valid), .item(f_item));

  // Queue decouples the front end from the arithmetic; the back end always drains it.
  sep_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(f_valid), .in_ready(q_in_ready), .in_item(f_item),
    .out_valid(q_valid), .out_ready(1'b1), .out_item(q_item));

  sep_trig u_trig (
    .clk(clk), .rst(rst), .in_valid(q_valid), .in_tag(q_item.tag), .in_t(q_item.t),
    .out_valid(t_valid), .out_tag(t_tag), .out_cos(t_cos), .out_sin(t_sin));

  // Route octant values to the axes; the front end already folded in the swap.
  assign mag_x = t_tag.x_from_sin ? t_sin : t_cos;
  assign mag_y = t_tag.x_from_sin ? t_cos : t_sin;

  sep_lane u_lane_x (
    .clk(clk), .rst(rst), .in_valid(t_valid), .in_mag(mag_x), .in_neg(t_tag.x_neg),
    .center(center_x), .axis(axis_x_len), .shape(shape_exponent),
    .out_valid(x_valid), .out_point(point_x));

  sep_lane u_lane_y (
    .clk(clk), .rst(rst), .in_valid(t_valid), .in_mag(mag_y), .in_neg(t_tag.y_neg),
    .center(center_y), .axis(axis_y_len), .shape(shape_exponent),
    .out_valid(y_valid), .out_point(point_y));

  // Both lanes run in lockstep.
  assign done = x_valid & y_valid;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the superellipse point generator: random and directed
// phase requests under several register settings. Depends on sep_pkg and the RTL top.

class sep_point_board;
  logic [10:0] cx, cy;
  logic [9:0]  ax, ay;
  logic [14:0] ex;
  logic signed [16:0] want_x[$];
  logic signed [16:0] want_y[$];
  int errors;

  function new();
    cx = 512; cy = 384; ax = 100; ay = 100; ex = 2560; errors = 0;
  endfunction

  function void write_reg(sep_pkg::sep_reg_t idx, logic [14:0] d);
    case (idx)
      sep_pkg::REG_CENTER_X:  cx = d[10:0];
      sep_pkg::REG_CENTER_Y:  cy = d[10:0];
      sep_pkg::REG_AXIS_X:    ax = d[9:0];
      sep_pkg::REG_AXIS_Y:    ay = d[9:0];
      sep_pkg::REG_SHAPE_EXP: ex = d;
      default: ;
    endcase
  endfunction

  // cos/sin magnitudes in Q30 for an octant offset t in [0, 8192]
  function void octant(input logic [63:0] t, output logic [63:0] c, output logic [63:0] s);
    logic [63:0] th, x2, h, one;
    one = 64'd1 << 30;
    th = (t * 64'd1686629713) >> 14;
    x2 = (th * th) >> 30;
    h = one - x2 / 56;
    h = one - ((x2 * h) >> 30) / 30;
    h = one - ((x2 * h) >> 30) / 12;
    c = one - ((x2 * h) >> 30) / 2;
    h = one - x2 / 72;
    h = one - ((x2 * h) >> 30) / 42;
    h = one - ((x2 * h) >> 30) / 20;
    h = one - ((x2 * h) >> 30) / 6;
    s = (th * h) >> 30;
  endfunction

  // m^(2/n) in Q30 via -log2 by squaring and a short exp series
  function logic [63:0] power(logic [63:0] m, logic [63:0] e);
    int msb;
    logic [63:0] x, fr, lg, p, ip, y, h, one;
    one = 64'd1 << 30;
    if (m == 0) return 0;
    msb = 0;
    while (msb < 30 && (m >> (msb + 1)) != 0) msb++;
    x = m << (30 - msb);
    fr = 0;
    for (int i = 0; i < 16; i++) begin
      x = (x * x) >> 30;
      fr = fr << 1;
      if (x >= (one << 1)) begin
        x = x >> 1;
        fr = fr | 1;
      end
    end
    lg = 64'(30 - msb) * 65536 - fr;
    p = (lg * 512) / e;
    ip = p >> 16;
    if (ip >= 31) return 0;
    y = ((p & 64'hFFFF) * 64'd744261118) >> 16;
    h = one;
    for (int k = 12; k >= 1; k--) h = one - ((y * h) >> 30) / k;
    return h >> ip;
  endfunction

  function logic signed [16:0] coord(logic [10:0] ctr, logic [9:0] axis, logic [63:0] mag,
                                     bit neg, logic [63:0] e);
    logic [63:0] term;
    longint v;
    term = (power(mag, e) * axis + (64'd1 << 25)) >> 26;
    v = longint'(ctr) << 4;
    v = neg ? v - longint'(term) : v + longint'(term);
    if (v > 65535) v = 65535;
    if (v < -65536) v = -65536;
    return v[16:0];
  endfunction

  function void note_request(logic [15:0] phase);
    logic [63:0] t, c1, s1, cm, sm, e;
    bit cn, sn;
    e = (ex == 0) ? 1 : ex;
    t = phase[13:0];
    if (t > 8192) octant(16384 - t, s1, c1);
    else octant(t, c1, s1);
    case (phase[15:14])
      2'd0: begin cm = c1; sm = s1; cn = 0; sn = 0; end
      2'd1: begin cm = s1; sm = c1; cn = 1; sn = 0; end
      2'd2: begin cm = c1; sm = s1; cn = 1; sn = 1; end
      default: begin cm = s1; sm = c1; cn = 0; sn = 1; end
    endcase
    want_x.push_back(coord(cx, ax, cm, cn, e));
    want_y.push_back(coord(cy, ay, sm, sn, e));
  endfunction

  function void check_point(logic signed [16:0] px, logic signed [16:0] py);
    logic signed [16:0] wx, wy;
    if (want_x.size() == 0) begin
      $display("%0t: unexpected point x=%0d y=%0d", $time, px, py);
      errors++;
      return;
    end
    wx = want_x.pop_front();
    wy = want_y.pop_front();
    if (px !== wx) begin
      $display("%0t: point_x expected %0d actual %0d", $time, wx, px);
      errors++;
    end
    if (py !== wy) begin
      $display("%0t: point_y expected %0d actual %0d", $time, wy, py);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import sep_pkg::*;

  localparam int LATENCY = 105;
  localparam int WATCHDOG = 4000;

  logic clk, rst, start, busy, cfg_valid, cfg_ready, done;
  logic [PHASE_W-1:0] phase_turns;
  logic [IDX_W-1:0]   cfg_index;
  logic [EXP_W-1:0]   cfg_data;
  logic signed [PT_W-1:0] point_x, point_y;

  sep_point_board board;
  int idle_cycles;

  superellipse_point_generator DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .phase_turns(phase_turns),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .point_x(point_x), .point_y(point_y)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one, and often none at all.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Hold one request until the block takes it; keep start high for back-to-back requests.
  task automatic send_phase(logic [15:0] ph);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      start <= 0;
      repeat (gap) @(negedge clk);
    end
    start <= 1;
    phase_turns <= ph;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_request(ph);
    @(negedge clk);
  endtask

  task automatic drop_start();
    start <= 0;
  endtask

  // Leave cfg_valid high so writes can follow back to back; the caller drops it.
  task automatic write_reg(sep_reg_t idx, logic [14:0] d);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.write_reg(idx, d);
    @(negedge clk);
  endtask

  // Wait until every expected point has come back, then let the pipe drain.
  task automatic settle();
    drop_start();
    while (board.want_x.size() != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic apply_setting(logic [10:0] cx, logic [10:0] cy, logic [9:0] ax,
                               logic [9:0] ay, logic [14:0] ex);
    settle();
    write_reg(REG_CENTER_X, 15'(cx));
    write_reg(REG_CENTER_Y, 15'(cy));
    write_reg(REG_AXIS_X, 15'(ax));
    write_reg(REG_AXIS_Y, 15'(ay));
    write_reg(REG_SHAPE_EXP, ex);
    cfg_valid <= 0;
  endtask

  // Phases skew toward quadrant edges and octant midpoints, where the series swap.
  function automatic logic [15:0] pick_phase();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return 16'({$urandom_range(0, 3), 14'd0} + $urandom_range(0, 4) - 2);
    if (r < 3) return 16'({$urandom_range(0, 3), 14'd8192} + $urandom_range(0, 4) - 2);
    return 16'($urandom_range(0, 65535));
  endfunction

  // Accept results at the rising edge; the watchdog counts edges with no traffic.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (done) board.check_point(point_x, point_y);
      if (done || (start && !busy) || (cfg_valid && cfg_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [15:0] edges [0:13];
    board = new();
    rst = 1;
    start = 0;
    phase_turns = 0;
    cfg_valid = 0;
    cfg_index = REG_CENTER_X;
    cfg_data = 0;
    repeat (12) @(negedge clk);
    rst = 0;

    // Directed: axes, octant midpoints, wrap edges, all-ones, under reset defaults.
    edges = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000, 16'h6000, 16'hA000,
              16'hE000, 16'hFFFF, 16'h0001, 16'h3FFF, 16'h2001, 16'h5555, 16'hAAAA};
    foreach (edges[i]) send_phase(edges[i]);

    // Zero exponent with vanishing power, a large exponent, and extreme corners and axes.
    apply_setting(11'd2047, 11'd0, 10'd1023, 10'd1023, 15'd0);
    foreach (edges[i]) if (i < 6) send_phase(edges[i]);
    apply_setting(11'd0, 11'd2047, 10'd1023, 10'd1023, 15'd25600);
    foreach (edges[i]) if (i < 5) send_phase(edges[i]);
    apply_setting(11'd1024, 11'd768, 10'd0, 10'd0, 15'h7FFF);
    send_phase(16'h1234);
    send_phase(16'hF0F0);

    // Random phases across a range of register settings, extremes included.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: apply_setting(11'd512, 11'd384, 10'd100, 10'd100, 15'd2560);
        1: apply_setting(11'd2047, 11'd2047, 10'd1023, 10'd1023, 15'd1);
        2: apply_setting(11'd0, 11'd0, 10'd1023, 10'd1023, 15'd256);
        3: apply_setting(11'd1024, 11'd768, 10'd500, 10'd300, 15'd512);
        default: apply_setting(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)),
                               10'($urandom_range(0, 1023)), 10'($urandom_range(0, 1023)),
                               15'($urandom_range(0, 32767)));
      endcase
      for (int n = 0; n < 160; n++) send_phase(pick_phase());
    end

    settle();
    if (board.errors == 0 && board.want_x.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
